### hdl/mufs_pkg.sv
// shared types and constants for the multi-universe frame sync unit
package mufs_pkg;

	localparam int unsigned MASK_W   = 16;
	localparam int unsigned TICK_W   = 32;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned TMO_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [MASK_W-1:0] mask_t;
	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [TMO_W-1:0]  tmo_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_TIMEOUT = 2'd2;

	// status codes
	localparam logic [1:0] STAT_NONE    = 2'd0;
	localparam logic [1:0] STAT_SHOW    = 2'd1;
	localparam logic [1:0] STAT_TIMEOUT = 2'd2;

	// show reasons
	localparam logic [2:0] REASON_NONE    = 3'd0;
	localparam logic [2:0] REASON_HARD    = 3'd1;
	localparam logic [2:0] REASON_FREE    = 3'd2;
	localparam logic [2:0] REASON_FULL    = 3'd3;
	localparam logic [2:0] REASON_MISSED  = 3'd4;
	localparam logic [2:0] REASON_TIMEOUT = 3'd5;

	// one accepted input beat
	typedef struct packed {
		logic  dmx;
		logic  hard;
		mask_t data;
		tick_t now;
		logic  test;
	} item_t;

endpackage

### hdl/multi_universe_frame_sync_unit.sv
// frame-sync decision for a frame built from several dmx universes
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_ready   dmx_event sync_event updated_mask now_tick test_active
// out      source     out_valid / out_ready load_mask status sync_reason pending_missed wake_tick
// cfg      sink       cfg_valid / cfg_ready cfg_index cfg_data (cfg_ready is always high)
//
// one beat per cycle sustained while the result side takes beats; each input beat passes
// the input register, then the decision logic into the result register
// the decision and the frame state update happen as a beat moves from the input
// register into the result register, so back-to-back beats see up-to-date state
// a stalled result holds the input register; the input side stalls only when both are full
// reset clears the frame state, the registers (universe count 1) and both valid flags
module multi_universe_frame_sync_unit
	import mufs_pkg::*;
#(
	parameter int unsigned MAX_UNIVERSES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  dmx_event,
	input  logic                  sync_event,
	input  logic [MASK_W-1:0]     updated_mask,
	input  logic [TICK_W-1:0]     now_tick,
	input  logic                  test_active,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [MASK_W-1:0]     load_mask,
	output logic [1:0]            status,
	output logic [2:0]            sync_reason,
	output logic [MASK_W-1:0]     pending_missed,
	output logic [TICK_W-1:0]     wake_tick,
	// register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// at most this many universes take part
	localparam int unsigned LIM = (MAX_UNIVERSES < MASK_W) ? MAX_UNIVERSES : MASK_W;

	// registers
	count_t universe_count_q;
	tmo_t   sync_tmo_q;
	tmo_t   signal_tmo_q;

	// frame state
	mask_t  received_q;
	mask_t  missed_q;
	tick_t  sync_dl_q;
	tick_t  signal_dl_q;

	// input register
	logic   valid_s1;
	item_t  item_s1;

	// result register
	logic   out_valid_q;
	mask_t  load_q;
	logic [1:0] status_q;
	logic [2:0] reason_q;
	mask_t  pending_q;
	tick_t  wake_q;

	logic   advance;

	// decision outputs
	mask_t  nx_received;
	mask_t  nx_missed;
	tick_t  nx_sync_dl;
	tick_t  nx_signal_dl;
	mask_t  nx_load;
	logic [1:0] nx_status;
	logic [2:0] nx_reason;
	tick_t  nx_wake;

	assign cfg_ready = 1'b1;

	// input register moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			universe_count_q <= count_t'(1);
			sync_tmo_q       <= '0;
			signal_tmo_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_UNIVERSE_COUNT: universe_count_q <= cfg_data[CNT_W-1:0];
				CFG_SYNC_TIMEOUT:   sync_tmo_q       <= cfg_data[TMO_W-1:0];
				CFG_SIGNAL_TIMEOUT: signal_tmo_q     <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.dmx  <= dmx_event;
			item_s1.hard <= sync_event;
			item_s1.data <= updated_mask;
			item_s1.now  <= now_tick;
			item_s1.test <= test_active;
		end
	end

	// decision logic, all per-universe bits in parallel
	always_comb begin
		count_t n;
		count_t n_act;
		count_t n_full;
		mask_t  act;
		mask_t  fm;
		logic   full_ok;
		mask_t  d;
		mask_t  recv;
		logic   miss;
		logic   evt;
		logic   soft_evt;
		tick_t  now;
		tick_t  sync_sum;
		tick_t  sig_sum;
		tick_t  dl1;
		logic   show;
		logic   tmo;

		n      = (universe_count_q == '0) ? count_t'(1) : universe_count_q;
		n_act  = (n > count_t'(LIM)) ? count_t'(LIM) : n;
		n_full = (n > count_t'(MAX_UNIVERSES)) ? count_t'(MAX_UNIVERSES) : n;
		// a frame wider than the mask can never be complete
		full_ok = (n_full <= count_t'(MASK_W));
		for (int i = 0; i < MASK_W; i++) begin
			act[i] = (count_t'(i) < n_act);
			fm[i]  = (count_t'(i) < n_full);
		end

		now      = item_s1.now;
		sync_sum = now + tick_t'(sync_tmo_q);
		sig_sum  = now + tick_t'(signal_tmo_q);

		// universes left over from a miss are replayed with this beat
		miss     = (missed_q != '0);
		d        = (item_s1.data | missed_q) & act;
		evt      = item_s1.dmx || item_s1.hard || miss;
		soft_evt = evt && !item_s1.hard;

		recv        = soft_evt ? (received_q | d) : received_q;
		nx_missed   = soft_evt ? (d & received_q) : '0;
		nx_load     = '0;
		if (evt) begin
			if (item_s1.hard) begin
				nx_load = d;
			end else begin
				nx_load = (d & ~received_q) | (miss ? (d & received_q) : '0);
			end
		end

		// arm the soft-sync deadline on the first universe of a frame
		dl1 = sync_dl_q;
		if (soft_evt && d != '0) begin
			if (sync_tmo_q == '0) begin
				dl1 = '0;
			end else if (sync_dl_q == '0) begin
				dl1 = sync_sum;
			end
		end

		show      = 1'b1;
		nx_reason = REASON_NONE;
		priority if (item_s1.hard) begin
			nx_reason = REASON_HARD;
		end else if (sync_tmo_q == '0 && recv != '0) begin
			nx_reason = REASON_FREE;
		end else if (full_ok && recv == fm) begin
			nx_reason = REASON_FULL;
		end else if (nx_missed != '0) begin
			nx_reason = REASON_MISSED;
		end else if (dl1 != '0 && now >= dl1) begin
			nx_reason = REASON_TIMEOUT;
		end else begin
			show = 1'b0;
		end

		// loss-of-signal deadline, renewed by every data or sync beat
		tmo          = 1'b0;
		nx_signal_dl = signal_dl_q;
		if (item_s1.dmx || item_s1.hard) begin
			nx_signal_dl = (signal_tmo_q != '0) ? sig_sum : '0;
		end else if (signal_dl_q != '0 && now >= signal_dl_q) begin
			tmo          = 1'b1;
			nx_signal_dl = (signal_tmo_q != '0) ? sig_sum : '0;
		end

		nx_received = recv;
		nx_sync_dl  = dl1;
		if (show) begin
			nx_received = '0;
			nx_sync_dl  = (nx_missed != '0 && sync_tmo_q != '0) ? sync_sum : '0;
		end

		nx_status = tmo ? STAT_TIMEOUT : (show ? STAT_SHOW : STAT_NONE);

		priority if (nx_missed != '0) begin
			nx_wake = now;
		end else if (nx_sync_dl != '0) begin
			nx_wake = nx_sync_dl;
		end else if (nx_signal_dl != '0 && !item_s1.test) begin
			nx_wake = nx_signal_dl;
		end else begin
			nx_wake = '0;
		end
	end

	// frame state commits as the beat enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			received_q  <= '0;
			missed_q    <= '0;
			sync_dl_q   <= '0;
			signal_dl_q <= '0;
		end else if (advance) begin
			received_q  <= nx_received;
			missed_q    <= nx_missed;
			sync_dl_q   <= nx_sync_dl;
			signal_dl_q <= nx_signal_dl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			load_q    <= nx_load;
			status_q  <= nx_status;
			reason_q  <= nx_reason;
			pending_q <= nx_missed;
			wake_q    <= nx_wake;
		end
	end

	assign out_valid      = out_valid_q;
	assign load_mask      = load_q;
	assign status         = status_q;
	assign sync_reason    = reason_q;
	assign pending_missed = pending_q;
	assign wake_tick      = wake_q;

`ifndef SYNTHESIS
	// no frame shown means no reason given
	a_none_no_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == STAT_NONE |-> reason_q == REASON_NONE)
		else $error("reason given without a frame shown");

	// a deferred universe always forces a show
	a_missed_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pending_q != '0 |-> status_q != STAT_NONE && reason_q != REASON_NONE)
		else $error("miss pending without a show");

	// a hard sync loads everything, so nothing is deferred
	a_hard_no_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && reason_q == REASON_HARD |-> pending_q == '0)
		else $error("miss pending after hard sync");

	// the result register is never overwritten while it waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("result overwritten while stalled");
`endif

endmodule

### bench/multi_universe_frame_sync_unit_tb.sv
// self-checking testbench for the multi-universe frame sync unit: directed rows, then random phases
module multi_universe_frame_sync_unit_tb;
	import mufs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNIV_LIMIT = 16;
	// index 3 has no register behind it, a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// one result beat as the block should present it
	typedef struct packed {
		mask_t      load;
		logic [1:0] status;
		logic [2:0] reason;
		mask_t      pend;
		tick_t      wake;
	} result_t;

	// one row of the directed part: a register write or an input beat
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0]          val;
		item_t                it;
		bit                   typed;
		result_t              want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  dmx_event = 1'b0;
	logic                  sync_event = 1'b0;
	logic [MASK_W-1:0]     updated_mask = '0;
	logic [TICK_W-1:0]     now_tick = '0;
	logic                  test_active = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [MASK_W-1:0]     load_mask;
	logic [1:0]            status;
	logic [2:0]            sync_reason;
	logic [MASK_W-1:0]     pending_missed;
	logic [TICK_W-1:0]     wake_tick;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers and the frame state
	count_t uc;
	tmo_t   sync_tmo;
	tmo_t   sig_tmo;
	mask_t  recv_m;
	mask_t  miss_m;
	tick_t  sync_dl;
	tick_t  sig_dl;

	result_t due_results[$];
	result_t head;
	row_t    plan[$];
	tick_t   tick_now;
	int      fails = 0;
	int      gap_pct = 0;
	int      stall_pct = 0;
	int      hold_asks = 0;
	int      holds_taken = 0;
	int      hold_left = 0;

	int unsigned ph_uc[8]    = '{16, 4, 1, 16, 0, 31, 8, 2};
	int unsigned ph_sync[8]  = '{0, 8, 1, 65535, 20, 12, 0, 6};
	int unsigned ph_sig[8]   = '{0, 40, 1, 65535, 0, 30, 100, 65535};

	multi_universe_frame_sync_unit #(
		.MAX_UNIVERSES(UNIV_LIMIT)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.dmx_event      (dmx_event),
		.sync_event     (sync_event),
		.updated_mask   (updated_mask),
		.now_tick       (now_tick),
		.test_active    (test_active),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.load_mask      (load_mask),
		.status         (status),
		.sync_reason    (sync_reason),
		.pending_missed (pending_missed),
		.wake_tick      (wake_tick),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// universes that take part in a frame; a count of zero behaves as one,
	// anything past the limit is clamped, so the full frame is this mask too
	function automatic mask_t active_mask();
		int n;
		n = (uc == 0) ? 1 : ((uc > UNIV_LIMIT) ? UNIV_LIMIT : int'(uc));
		return mask_t'((32'd1 << n) - 1);
	endfunction

	// frame decision for one event, advancing the predictor state
	function automatic result_t frame_decide(input item_t it);
		mask_t      act;
		mask_t      data;
		logic       miss;
		logic       show;
		logic       lost;
		logic [2:0] why;
		result_t    r;
		act  = active_mask();
		data = it.data;
		miss = 1'b0;
		show = 1'b0;
		lost = 1'b0;
		why  = REASON_NONE;
		r    = '0;
		// deferred universes from the last event are folded back in and loaded now
		if (miss_m != '0) begin
			data   = data | miss_m;
			miss   = 1'b1;
			miss_m = '0;
		end
		if (it.dmx || it.hard || miss) begin
			for (int i = 0; i < MASK_W; i++) begin
				if (act[i] && data[i]) begin
					if (it.hard) begin
						r.load[i] = 1'b1;
					end else begin
						// second arrival within one frame is deferred, and loaded only on a replay beat
						if (!recv_m[i]) begin
							recv_m[i] = 1'b1;
							r.load[i] = 1'b1;
						end else begin
							miss_m[i] = 1'b1;
							if (miss)
								r.load[i] = 1'b1;
						end
						if (sync_tmo != '0) begin
							if (sync_dl == '0)
								sync_dl = it.now + sync_tmo;
						end else begin
							sync_dl = '0;
						end
					end
				end
			end
		end
		// show reasons in priority order
		if (it.hard) begin
			show = 1'b1;
			why  = REASON_HARD;
		end else if (sync_tmo == '0 && recv_m != '0) begin
			show = 1'b1;
			why  = REASON_FREE;
		end else if (recv_m == act) begin
			show = 1'b1;
			why  = REASON_FULL;
		end else if (miss_m != '0) begin
			show = 1'b1;
			why  = REASON_MISSED;
		end else if (sync_dl != '0 && it.now >= sync_dl) begin
			show = 1'b1;
			why  = REASON_TIMEOUT;
		end
		// loss of signal: renewed by any packet, fires only on a timer wake
		if (it.dmx || it.hard) begin
			sig_dl = (sig_tmo != '0) ? tick_t'(it.now + sig_tmo) : tick_t'(0);
		end else if (sig_dl != '0 && it.now >= sig_dl) begin
			lost   = 1'b1;
			sig_dl = (sig_tmo != '0) ? tick_t'(it.now + sig_tmo) : tick_t'(0);
		end
		if (show) begin
			recv_m  = '0;
			sync_dl = (miss_m != '0 && sync_tmo != '0) ? tick_t'(it.now + sync_tmo)
				: tick_t'(0);
		end
		if (miss_m != '0)
			r.wake = it.now;
		else if (sync_dl != '0)
			r.wake = sync_dl;
		else if (sig_dl != '0 && !it.test)
			r.wake = sig_dl;
		else
			r.wake = '0;
		r.status = lost ? STAT_TIMEOUT : (show ? STAT_SHOW : STAT_NONE);
		r.reason = why;
		r.pend   = miss_m;
		return r;
	endfunction

	// random event, mostly new universes of the current frame on a slowly moving clock
	function automatic item_t next_event(input int unsigned span);
		item_t       it;
		int unsigned r;
		mask_t       act;
		act = active_mask();
		r   = $urandom_range(99);
		if (r < 70)
			tick_now += $urandom_range(0, 3);
		else if (r < 96)
			tick_now += $urandom_range(0, span);
		else
			tick_now = $urandom;
		it.now = tick_now;
		r = $urandom_range(99);
		if (r < 72) begin
			it.dmx  = 1'b1;
			it.hard = 1'b0;
		end else if (r < 78) begin
			it.dmx  = 1'($urandom_range(1));
			it.hard = 1'b1;
		end else if (r < 94) begin
			it.dmx  = 1'b0;
			it.hard = 1'b0;
		end else begin
			it.dmx  = 1'b1;
			it.hard = 1'b0;
		end
		r = $urandom_range(99);
		if (r < 65)
			it.data = ~recv_m & act & mask_t'($urandom | $urandom);
		else if (r < 85)
			it.data = mask_t'($urandom);
		else
			it.data = act & (mask_t'(1) << $urandom_range(0, 15));
		it.test = ($urandom_range(99) < 10);
		return it;
	endfunction

	function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		row_t w;
		w        = '{default: '0};
		w.is_cfg = 1'b1;
		w.idx    = idx;
		w.val    = val;
		plan.push_back(w);
	endfunction

	function automatic void item_row(input item_t it);
		row_t w;
		w    = '{default: '0};
		w.it = it;
		plan.push_back(w);
	endfunction

	function automatic void typed_row(input item_t it, input result_t want);
		row_t w;
		w       = '{default: '0};
		w.it    = it;
		w.typed = 1'b1;
		w.want  = want;
		plan.push_back(w);
	endfunction

	task automatic log_mismatch(input string what);
		fails++;
		if (fails <= 10)
			$display("%0t ns: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want)
			log_mismatch($sformatf("%s: expected %h, got %h", name, want, got));
	endtask

	// lower both sender valids, wait until every result is back, then let the pipe settle
	task automatic drain_results();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write; cfg_valid is left high so writes can go back to back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_UNIVERSE_COUNT: uc = val[CNT_W-1:0];
			CFG_SYNC_TIMEOUT:   sync_tmo = val;
			CFG_SIGNAL_TIMEOUT: sig_tmo = val;
			default: ;
		endcase
	endtask

	// offer one event beat, with random idle cycles ahead of it, and queue its result
	task automatic push_item(input item_t it, input bit typed, input result_t want);
		result_t guess;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		dmx_event    <= it.dmx;
		sync_event   <= it.hard;
		updated_mask <= it.data;
		now_tick     <= it.now;
		test_active  <= it.test;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// state moves on for typed rows too
		guess = frame_decide(it);
		due_results.push_back(typed ? want : guess);
	endtask

	// result side: random stalls, plus a long hold-off on request so the block backs up
	always @(posedge clk) begin
		if (hold_asks != holds_taken) begin
			holds_taken = hold_asks;
			hold_left   = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				log_mismatch("result beat with nothing due");
			end else begin
				head = due_results.pop_front();
				check_field("load_mask", 32'(head.load), 32'(load_mask));
				check_field("status", 32'(head.status), 32'(status));
				check_field("sync_reason", 32'(head.reason), 32'(sync_reason));
				check_field("pending_missed", 32'(head.pend), 32'(pending_missed));
				check_field("wake_tick", head.wake, wake_tick);
			end
		end
	end

	initial begin
		bit          writing;
		int unsigned u;
		int unsigned s;
		int unsigned g;
		int unsigned span;
		int unsigned r;
		// reset values of the registers and frame state
		uc       = count_t'(1);
		sync_tmo = '0;
		sig_tmo  = '0;
		recv_m   = '0;
		miss_m   = '0;
		sync_dl  = '0;
		sig_dl   = '0;
		writing  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, fields: dmx, hard, data, now, test
		// nothing at all straight after reset
		typed_row(item_t'{1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
			result_t'{16'h0000, STAT_NONE, REASON_NONE, 16'h0000, 32'h0});
		// every universe on the top tick: one universe per frame, free running
		typed_row(item_t'{1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1},
			result_t'{16'h0001, STAT_SHOW, REASON_FREE, 16'h0000, 32'h0});
		// hard sync with data
		typed_row(item_t'{1'b1, 1'b1, 16'hFFFF, 32'h0000_0000, 1'b0},
			result_t'{16'h0001, STAT_SHOW, REASON_HARD, 16'h0000, 32'h0});
		// hard sync alone
		typed_row(item_t'{1'b0, 1'b1, 16'h0000, 32'h0000_0005, 1'b0},
			result_t'{16'h0000, STAT_SHOW, REASON_HARD, 16'h0000, 32'h0});
		// data flagged on a timer wake is ignored
		typed_row(item_t'{1'b0, 1'b0, 16'hFFFF, 32'h0000_0006, 1'b0},
			result_t'{16'h0000, STAT_NONE, REASON_NONE, 16'h0000, 32'h0});
		// universe count of zero acts as one
		cfg_row(CFG_UNIVERSE_COUNT, 16'hFFE0);
		item_row(item_t'{1'b1, 1'b0, 16'h0002, 32'd7, 1'b0});
		item_row(item_t'{1'b1, 1'b0, 16'h0001, 32'd8, 1'b0});
		// count past the limit, longest timeouts, and a write to no register
		cfg_row(CFG_UNIVERSE_COUNT, 16'h001F);
		cfg_row(CFG_SYNC_TIMEOUT, 16'hFFFF);
		cfg_row(CFG_SIGNAL_TIMEOUT, 16'hFFFF);
		cfg_row(CFG_UNUSED, 16'hFFFF);
		item_row(item_t'{1'b1, 1'b0, 16'h00FF, 32'd10, 1'b0});
		// repeat arrival: deferred, shown as missed
		item_row(item_t'{1'b1, 1'b0, 16'h0003, 32'd20, 1'b0});
		item_row(item_t'{1'b0, 1'b0, 16'h0000, 32'd30, 1'b0});
		// sync deadline and signal deadline both pass, under test pattern
		item_row(item_t'{1'b0, 1'b0, 16'h0000, 32'd70000, 1'b1});
		// all sixteen in: full frame
		item_row(item_t'{1'b1, 1'b0, 16'hFFFF, 32'd100000, 1'b0});
		// deadline sum wraps to exactly zero and stays unarmed
		cfg_row(CFG_SYNC_TIMEOUT, 16'h0010);
		cfg_row(CFG_SIGNAL_TIMEOUT, 16'h0000);
		item_row(item_t'{1'b1, 1'b0, 16'h0001, 32'hFFFF_FFF0, 1'b0});
		// miss at tick zero: immediate wake reads as zero
		item_row(item_t'{1'b1, 1'b0, 16'h0001, 32'h0000_0000, 1'b0});
		item_row(item_t'{1'b0, 1'b0, 16'h0000, 32'd5, 1'b0});
		// shortest signal timeout, firing while a test pattern runs
		cfg_row(CFG_SIGNAL_TIMEOUT, 16'h0001);
		cfg_row(CFG_UNIVERSE_COUNT, 16'h0002);
		item_row(item_t'{1'b1, 1'b0, 16'h0001, 32'd100, 1'b1});
		item_row(item_t'{1'b0, 1'b0, 16'h0000, 32'd200, 1'b1});
		item_row(item_t'{1'b0, 1'b0, 16'h0000, 32'd300, 1'b0});

		gap_pct   = 34;
		stall_pct = 34;
		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				if (!writing)
					drain_results();
				writing = 1'b1;
				write_reg(plan[k].idx, plan[k].val);
			end else begin
				writing = 1'b0;
				push_item(plan[k].it, plan[k].typed, plan[k].want);
			end
		end

		// random phases, each with its own settings and idling pattern
		for (int p = 0; p < 12; p++) begin
			drain_results();
			if (p < 8) begin
				u = ph_uc[p];
				s = ph_sync[p];
				g = ph_sig[p];
			end else begin
				u = $urandom_range(0, 31);
				r = $urandom_range(99);
				s = (r < 20) ? 0 : $urandom_range(1, 80);
				r = $urandom_range(99);
				g = (r < 30) ? 0 : $urandom_range(1, 200);
			end
			// junk in the unused upper bits of the count write
			write_reg(CFG_UNIVERSE_COUNT, 16'(($urandom_range(0, 2047) << CNT_W) | u));
			write_reg(CFG_SYNC_TIMEOUT, 16'(s));
			write_reg(CFG_SIGNAL_TIMEOUT, 16'(g));
			case (p % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 59;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 59;
				end
				default: begin
					gap_pct   = 34;
					stall_pct = 34;
				end
			endcase
			span = 2 * ((s > g) ? s : g) + 4;
			// some phases start just short of the tick wrap
			if (p % 3 == 2)
				tick_now = 32'hFFFF_FFFF - $urandom_range(0, 400);
			else
				tick_now = $urandom;
			for (int k = 0; k < 154; k++) begin
				if (p % 4 == 0 && k == 40)
					hold_asks++;
				push_item(next_event(span), 1'b0, '0);
			end
		end

		drain_results();
		if (fails == 0)
			$display("multi_universe_frame_sync_unit_tb: done, clean");
		else
			$display("multi_universe_frame_sync_unit_tb: done, errors");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("multi_universe_frame_sync_unit_tb: done, errors");
		$finish;
	end

endmodule
